// File: rtl/core/hrr_pkg.sv
// ----------------------------------------------------------------------------
// hrr_pkg
// Types and constants for the heartbeat record responder.
// ----------------------------------------------------------------------------
package hrr_pkg;

	localparam int unsigned PAD_BYTES = 16;
	localparam int unsigned HDR_BYTES = 3;

	localparam logic [7:0]  TYPE_REQUEST  = 8'd1;
	localparam logic [7:0]  TYPE_RESPONSE = 8'd2;
	localparam logic [15:0] ACK_PAYLOAD   = 16'd18;

	localparam logic [1:0] HDR_LAST_IDX = 2'(HDR_BYTES - 1);
	localparam logic [3:0] PAD_LAST_IDX = 4'(PAD_BYTES - 1);

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_ACK  = 1'b1;

	typedef struct packed {
		logic [7:0]  rec_byte;
		logic        rec_first;
		logic [15:0] rec_length;
	} rec_word_t;

	typedef struct packed {
		logic        out_kind;
		logic [7:0]  out_byte;
		logic        out_last;
		logic [15:0] out_seq;
	} rsp_word_t;

endpackage

// File: rtl/core/heartbeat_record_responder.sv
// ----------------------------------------------------------------------------
// heartbeat_record_responder
// Parses heartbeat records byte by byte, echoes requests, checks acks.
// ----------------------------------------------------------------------------
// Usage:
//   rec channel: one record byte per word with rec_first on byte 0 and the
//   total record length on every byte. rsp channel: response bytes (kind 0)
//   ending with out_last on the final pad byte, or ack words (kind 1) that
//   carry the acknowledged sequence number. cfg channel: pad byte, always
//   ready; write it only while the block is idle.
//   A result passes through the burst register (parse), then the output
//   register, before it appears on rsp.
//   Throughput: a record word that yields zero or one result is taken every
//   cycle while rsp_ready holds. Words that yield a burst (3-byte header,
//   header plus 16 pad bytes, or the last payload byte plus 16 pad bytes)
//   hold rec_ready low until the burst register is down to its last
//   result.
//   Reset: clears parse state, expected sequence, pad byte and the valid
//   flags of both result stages; burst payload and output data are not reset.
//   Stall: when rsp_ready is low the output register holds, the burst
//   register holds, and rec_ready drops once the burst register is busy.
// ----------------------------------------------------------------------------
module heartbeat_record_responder #(
	parameter int unsigned MAX_PLAIN_LENGTH = 16384
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rec_valid,
	output logic               rec_ready,
	input  hrr_pkg::rec_word_t rec,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output hrr_pkg::rsp_word_t rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_pad_value
);
	import hrr_pkg::*;

	localparam logic [16:0] MAX_TOTAL = 17'(MAX_PLAIN_LENGTH);
	localparam logic [16:0] MIN_LEN   = 17'(HDR_BYTES + PAD_BYTES);

	// parse state
	logic [15:0] bpos_q;
	logic [7:0]  mtype_q;
	logic [15:0] plen_q;
	logic        echo_q;
	logic        ackchk_q;
	logic [7:0]  seqhi_q;
	logic [31:0] expseq_q;
	logic [7:0]  pad_q;

	// burst register: which parts of the result burst are still owed
	logic        hdr_s1, echo_s1, padf_s1, ack_s1;
	logic [3:0]  cnt_s1;
	logic [15:0] pl_s1;
	logic [7:0]  byte_s1;
	logic [15:0] seq_s1;

	// output register
	logic        rsp_valid_s2;
	rsp_word_t   rsp_s2;

	logic        rec_acc;
	logic        pend, last_one, load_out, adv;
	rsp_word_t   cur;

	// next-state of parse
	logic [15:0] pos;
	logic        echo_eff, ack_eff;
	logic [15:0] pl;
	logic [16:0] total;
	logic [15:0] idx;
	logic [15:0] seq;
	logic        len_ok;

	logic [15:0] bpos_d, plen_d;
	logic [7:0]  mtype_d, seqhi_d;
	logic        echo_d, ackchk_d;
	logic [31:0] expseq_d;
	logic        hdr_d, echo_out_d, pad_d, ack_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= '0;
		end else if (cfg_valid) begin
			pad_q <= cfg_pad_value;
		end
	end

	// ---- parse logic for the word at the rec port ----
	always_comb begin
		pos      = rec.rec_first ? 16'd0 : bpos_q;
		echo_eff = rec.rec_first ? 1'b0 : echo_q;
		ack_eff  = rec.rec_first ? 1'b0 : ackchk_q;
		pl       = {plen_q[15:8], rec.rec_byte};
		total    = 17'(pl) + MIN_LEN;
		len_ok   = (17'(rec.rec_length) >= MIN_LEN) && (total <= 17'(rec.rec_length));
		idx      = pos - 16'(HDR_BYTES);
		seq      = {seqhi_q, rec.rec_byte};

		mtype_d    = mtype_q;
		plen_d     = plen_q;
		echo_d     = echo_eff;
		ackchk_d   = ack_eff;
		seqhi_d    = seqhi_q;
		expseq_d   = expseq_q;
		hdr_d      = 1'b0;
		echo_out_d = 1'b0;
		pad_d      = 1'b0;
		ack_d      = 1'b0;

		if (pos == 16'd0) begin
			mtype_d = rec.rec_byte;
			plen_d  = '0;
		end else if (pos == 16'd1) begin
			plen_d = {rec.rec_byte, 8'h00};
		end else if (pos == 16'd2) begin
			plen_d = pl;
			if (len_ok) begin
				if (mtype_q == TYPE_REQUEST) begin
					if (total <= MAX_TOTAL) begin
						hdr_d = 1'b1;
						if (pl == 16'd0)
							pad_d = 1'b1;
						else
							echo_d = 1'b1;
					end
				end else if (mtype_q == TYPE_RESPONSE) begin
					ackchk_d = (pl == ACK_PAYLOAD);
				end
			end
		end else begin
			if (echo_eff) begin
				if (idx < plen_q) begin
					echo_out_d = 1'b1;
					if (idx + 16'd1 == plen_q) begin
						pad_d  = 1'b1;
						echo_d = 1'b0;
					end
				end else begin
					echo_d = 1'b0;
				end
			end
			if (ack_eff) begin
				if (pos == 16'd3) begin
					seqhi_d = rec.rec_byte;
				end else begin
					// upper half of the expected number must be zero to match
					if ({16'h0000, seq} == expseq_q) begin
						ack_d    = 1'b1;
						expseq_d = expseq_q + 32'd1;
					end
					ackchk_d = 1'b0;
				end
			end
		end

		bpos_d = (pos == 16'hFFFF) ? pos : pos + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpos_q   <= '0;
			mtype_q  <= '0;
			plen_q   <= '0;
			echo_q   <= 1'b0;
			ackchk_q <= 1'b0;
			seqhi_q  <= '0;
			expseq_q <= '0;
		end else if (rec_acc) begin
			bpos_q   <= bpos_d;
			mtype_q  <= mtype_d;
			plen_q   <= plen_d;
			echo_q   <= echo_d;
			ackchk_q <= ackchk_d;
			seqhi_q  <= seqhi_d;
			expseq_q <= expseq_d;
		end
	end

	// ---- burst sequencer: order is header, echo byte, padding, ack ----
	assign pend = hdr_s1 | echo_s1 | padf_s1 | ack_s1;

	assign last_one =
		(hdr_s1 && cnt_s1[1:0] == HDR_LAST_IDX && !echo_s1 && !padf_s1 && !ack_s1) ||
		(!hdr_s1 && echo_s1 && !padf_s1 && !ack_s1) ||
		(!hdr_s1 && !echo_s1 && padf_s1 && cnt_s1 == PAD_LAST_IDX && !ack_s1) ||
		(!hdr_s1 && !echo_s1 && !padf_s1 && ack_s1);

	assign load_out  = !rsp_valid_s2 || rsp_ready;
	assign adv       = pend && load_out;
	assign rec_ready = !pend || (last_one && adv);
	assign rec_acc   = rec_valid && rec_ready;

	always_comb begin
		cur          = '0;
		cur.out_kind = KIND_BYTE;
		if (hdr_s1) begin
			case (cnt_s1[1:0])
				2'd0:    cur.out_byte = TYPE_RESPONSE;
				2'd1:    cur.out_byte = pl_s1[15:8];
				default: cur.out_byte = pl_s1[7:0];
			endcase
		end else if (echo_s1) begin
			cur.out_byte = byte_s1;
		end else if (padf_s1) begin
			cur.out_byte = pad_q;
			cur.out_last = (cnt_s1 == PAD_LAST_IDX);
		end else if (ack_s1) begin
			cur.out_kind = KIND_ACK;
			cur.out_seq  = seq_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_s1  <= 1'b0;
			echo_s1 <= 1'b0;
			padf_s1 <= 1'b0;
			ack_s1  <= 1'b0;
			cnt_s1  <= '0;
		end else if (rec_acc) begin
			hdr_s1  <= hdr_d;
			echo_s1 <= echo_out_d;
			padf_s1 <= pad_d;
			ack_s1  <= ack_d;
			cnt_s1  <= '0;
		end else if (adv) begin
			if (hdr_s1) begin
				if (cnt_s1[1:0] == HDR_LAST_IDX) begin
					hdr_s1 <= 1'b0;
					cnt_s1 <= '0;
				end else begin
					cnt_s1 <= cnt_s1 + 4'd1;
				end
			end else if (echo_s1) begin
				echo_s1 <= 1'b0;
			end else if (padf_s1) begin
				if (cnt_s1 == PAD_LAST_IDX) begin
					padf_s1 <= 1'b0;
					cnt_s1  <= '0;
				end else begin
					cnt_s1 <= cnt_s1 + 4'd1;
				end
			end else begin
				ack_s1 <= 1'b0;
			end
		end
	end

	// burst payload, no reset needed
	always_ff @(posedge clk) begin
		if (rec_acc) begin
			pl_s1   <= pl;
			byte_s1 <= rec.rec_byte;
			seq_s1  <= seq;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (load_out) begin
			rsp_valid_s2 <= pend;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			rsp_s2 <= cur;
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

`ifndef SYNTHESIS
	// ack words carry no byte and no last mark; byte words carry no sequence
	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.out_kind == KIND_ACK) ?
			(rsp.out_byte == 8'h00 && !rsp.out_last) : (rsp.out_seq == 16'h0000))
		else $error("result fields inconsistent with kind");

	// while a burst is pending, a new record word is only taken when the burst register drains this cycle
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rec_acc && pend |-> last_one && adv)
		else $error("record word taken over a pending burst");

	// expected sequence moves only on an accepted record word that queued an ack
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		expseq_q != $past(expseq_q) |-> $past(rec_acc) && ack_s1)
		else $error("expected sequence changed without an ack");
`endif

endmodule
